// ----- src/rsqa_pkg.sv -----
// Shared constants, types and codes for the R squared accumulator.
package rsqa_pkg;

  localparam int MAX_SAMPLES   = 4096;
  localparam int SAMPLE_BITS   = 16;
  localparam int FRACTION_BITS = 16;

  localparam int CNT_W  = 13;
  localparam int SUM_W  = 29;
  localparam int SQ_W   = 43;
  localparam int RES_W  = 47;
  localparam int KSQ_W  = 2 * SAMPLE_BITS - 1;
  localparam int DSQ_W  = 2 * SAMPLE_BITS;
  localparam int SKSQ_W = 2 * SUM_W;
  localparam int D_W    = SQ_W + CNT_W;
  localparam int NUM_W  = RES_W + CNT_W;
  localparam int DVD_W  = NUM_W + FRACTION_BITS;
  localparam int DCNT_W = $clog2(DVD_W + 1);
  localparam int MCNT_W = $clog2(CNT_W);

  localparam int RSQ_W = 20;
  localparam int TSS_W = 42;
  localparam int RSS_W = 46;
  localparam int Q_W   = TSS_W;

  localparam logic [RSQ_W-1:0] RSQ_MIN = {1'b1, {(RSQ_W-1){1'b0}}};
  localparam logic [RSQ_W-1:0] RSQ_ONE = RSQ_W'(2 ** FRACTION_BITS);
  localparam logic [Q_W-1:0]   RSQ_SAT_Q = Q_W'(2 ** (RSQ_W - 1) + 2 ** FRACTION_BITS);

  typedef enum logic {
    DIV_SST,
    DIV_RSQ
  } rsqa_div_sel_t;

  typedef enum logic [2:0] {
    ST_ACC,
    ST_MUL,
    ST_SUB,
    ST_DIV1_GO,
    ST_DIV1_WAIT,
    ST_DIV2_GO,
    ST_DIV2_WAIT,
    ST_OUT
  } rsqa_state_t;

  typedef struct packed {
    logic          acc;
    logic          capture;
    logic          mul_step;
    logic          sub;
    logic          div_start;
    rsqa_div_sel_t div_sel;
    logic          sst_load;
    logic          rsq_load;
    logic          zero_load;
    logic          load_out;
  } rsqa_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic d_zero;
  } rsqa_sts_t;

endpackage

// ----- src/rsqa_div.sv -----
// Restoring divider that retires one quotient bit per cycle.
module rsqa_div import rsqa_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [D_W-1:0]   divisor,
  output logic [Q_W-1:0]   quotient,
  output logic             q_ovf,
  output logic             done
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DCNT_W-1:0] cnt_r, cnt_nxt;
  logic [DVD_W-1:0]  dvd_r;
  logic [D_W-1:0]    dsr_r;
  logic [D_W-1:0]    rem_r;
  logic [Q_W-1:0]    q_r;
  logic              ovf_r;
  logic [D_W:0]      rem_sh;
  logic [D_W:0]      rem_sub;
  logic              ge;

  assign rem_sh  = {rem_r, dvd_r[DVD_W-1]};
  assign ge      = rem_sh >= {1'b0, dsr_r};
  assign rem_sub = rem_sh - {1'b0, dsr_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DCNT_W'(DVD_W);
    end else if (busy_r) begin
      cnt_nxt = cnt_r - DCNT_W'(1);
      if (cnt_r == DCNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dsr_r <= divisor;
      rem_r <= '0;
      q_r   <= '0;
      ovf_r <= 1'b0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DVD_W-2:0], 1'b0};
      rem_r <= ge ? rem_sub[D_W-1:0] : rem_sh[D_W-1:0];
      q_r   <= {q_r[Q_W-2:0], ge};
      ovf_r <= ovf_r | q_r[Q_W-1];
    end
  end

  assign quotient = q_r;
  assign q_ovf    = ovf_r;
  assign done     = done_r;

endmodule

// ----- src/rsqa_dp.sv -----
// Datapath: running sums, shift-add products, final difference and result registers.
module rsqa_dp import rsqa_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rsqa_cmd_t                     cmd,
  output rsqa_sts_t                     sts,
  input  logic signed [SAMPLE_BITS-1:0] in_known_value,
  input  logic signed [SAMPLE_BITS-1:0] in_estimated_value,
  output logic signed [RSQ_W-1:0]       out_r_squared,
  output logic [TSS_W-1:0]              out_total_sum_squares,
  output logic [RSS_W-1:0]              out_residual_sum_squares,
  output logic [CNT_W-1:0]              out_sample_total,
  output logic                          out_zero_total,
  output logic                          out_count_overflow
);

  logic [SUM_W-1:0]  sk_r;
  logic [SQ_W-1:0]   sq_r;
  logic [RES_W-1:0]  sr_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              ovf_r;

  logic signed [SAMPLE_BITS:0]       diff;
  logic signed [2*SAMPLE_BITS-1:0]   k_ext;
  logic signed [2*SAMPLE_BITS+1:0]   diff_ext;
  logic signed [2*SAMPLE_BITS-1:0]   ksq_full;
  logic signed [2*SAMPLE_BITS+1:0]   dsq_full;
  logic [KSQ_W-1:0]  ksq;
  logic [DSQ_W-1:0]  dsq;
  logic              full;
  logic [SUM_W-1:0]  sk_n;
  logic [SQ_W-1:0]   sq_n;
  logic [RES_W-1:0]  sr_n;
  logic [CNT_W-1:0]  cnt_n;
  logic              ovf_n;

  logic [SUM_W-1:0]  sk_w_r;
  logic [RES_W-1:0]  sr_w_r;
  logic [CNT_W-1:0]  n_w_r;
  logic              ovf_w_r;
  logic [CNT_W-1:0]  mpl_r;
  logic [D_W-1:0]    mcd_d_r;
  logic [NUM_W-1:0]  mcd_n_r;
  logic [D_W-1:0]    prod_d_r;
  logic [NUM_W-1:0]  prod_n_r;
  logic [MCNT_W-1:0] mcnt_r;
  logic [SUM_W-1:0]  abs_sk;
  logic [SKSQ_W-1:0] abs_sk_ext;
  logic [SKSQ_W-1:0] sksq_r;
  logic [D_W-1:0]    d_r;

  logic [DVD_W-1:0]  div_dividend;
  logic [D_W-1:0]    div_divisor;
  logic [Q_W-1:0]    quotient;
  logic              q_ovf;
  logic              div_done;
  logic              rsq_sat;

  logic [TSS_W-1:0]  sst_r;
  logic [RSQ_W-1:0]  rsq_r;
  logic              zero_r;

  logic [RSQ_W-1:0]  out_rsq_r;
  logic [TSS_W-1:0]  out_tss_r;
  logic [RSS_W-1:0]  out_rss_r;
  logic [CNT_W-1:0]  out_cnt_r;
  logic              out_zero_r;
  logic              out_ovf_r;

  assign diff     = {in_known_value[SAMPLE_BITS-1], in_known_value}
                  - {in_estimated_value[SAMPLE_BITS-1], in_estimated_value};
  assign k_ext    = {{SAMPLE_BITS{in_known_value[SAMPLE_BITS-1]}}, in_known_value};
  assign diff_ext = {{(SAMPLE_BITS+1){diff[SAMPLE_BITS]}}, diff};
  assign ksq_full = k_ext * k_ext;
  assign dsq_full = diff_ext * diff_ext;
  assign ksq      = ksq_full[KSQ_W-1:0];
  assign dsq      = dsq_full[DSQ_W-1:0];
  assign full     = cnt_r >= CNT_W'(MAX_SAMPLES);

  always_comb begin
    sk_n  = sk_r;
    sq_n  = sq_r;
    sr_n  = sr_r;
    cnt_n = cnt_r;
    ovf_n = ovf_r | full;
    if (!full) begin
      sk_n  = sk_r + {{(SUM_W-SAMPLE_BITS){in_known_value[SAMPLE_BITS-1]}}, in_known_value};
      sq_n  = sq_r + {{(SQ_W-KSQ_W){1'b0}}, ksq};
      sr_n  = sr_r + {{(RES_W-DSQ_W){1'b0}}, dsq};
      cnt_n = cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sk_r  <= '0;
      sq_r  <= '0;
      sr_r  <= '0;
      cnt_r <= '0;
      ovf_r <= 1'b0;
    end else if (cmd.capture) begin
      sk_r  <= '0;
      sq_r  <= '0;
      sr_r  <= '0;
      cnt_r <= '0;
      ovf_r <= 1'b0;
    end else if (cmd.acc) begin
      sk_r  <= sk_n;
      sq_r  <= sq_n;
      sr_r  <= sr_n;
      cnt_r <= cnt_n;
      ovf_r <= ovf_n;
    end
  end

  assign abs_sk     = sk_w_r[SUM_W-1] ? (~sk_w_r + SUM_W'(1)) : sk_w_r;
  assign abs_sk_ext = {{(SKSQ_W-SUM_W){1'b0}}, abs_sk};

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sk_w_r   <= sk_n;
      sr_w_r   <= sr_n;
      n_w_r    <= cnt_n;
      ovf_w_r  <= ovf_n;
      mpl_r    <= cnt_n;
      mcd_d_r  <= {{(D_W-SQ_W){1'b0}}, sq_n};
      mcd_n_r  <= {{(NUM_W-RES_W){1'b0}}, sr_n};
      prod_d_r <= '0;
      prod_n_r <= '0;
      mcnt_r   <= '0;
    end else if (cmd.mul_step) begin
      if (mpl_r[0]) begin
        prod_d_r <= prod_d_r + mcd_d_r;
        prod_n_r <= prod_n_r + mcd_n_r;
      end
      mcd_d_r <= {mcd_d_r[D_W-2:0], 1'b0};
      mcd_n_r <= {mcd_n_r[NUM_W-2:0], 1'b0};
      mpl_r   <= {1'b0, mpl_r[CNT_W-1:1]};
      mcnt_r  <= mcnt_r + MCNT_W'(1);
      sksq_r  <= abs_sk_ext * abs_sk_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sub) begin
      if ({{(SKSQ_W-D_W){1'b0}}, prod_d_r} > sksq_r) begin
        d_r <= prod_d_r - sksq_r[D_W-1:0];
      end else begin
        d_r <= '0;
      end
    end
  end

  assign div_dividend = (cmd.div_sel == DIV_RSQ) ? {prod_n_r, {FRACTION_BITS{1'b0}}}
                                                 : {{(DVD_W-D_W){1'b0}}, d_r};
  assign div_divisor  = (cmd.div_sel == DIV_RSQ) ? d_r : {{(D_W-CNT_W){1'b0}}, n_w_r};

  rsqa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (quotient),
    .q_ovf    (q_ovf),
    .done     (div_done)
  );

  assign rsq_sat = q_ovf || (quotient > RSQ_SAT_Q);

  always_ff @(posedge clk) begin
    if (cmd.sst_load) begin
      sst_r <= quotient;
    end
    if (cmd.rsq_load) begin
      rsq_r  <= rsq_sat ? RSQ_MIN : (RSQ_ONE - quotient[RSQ_W-1:0]);
      zero_r <= 1'b0;
    end else if (cmd.zero_load) begin
      rsq_r  <= '0;
      zero_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_rsq_r  <= rsq_r;
      out_tss_r  <= sst_r;
      out_rss_r  <= sr_w_r[RSS_W-1:0];
      out_cnt_r  <= n_w_r;
      out_zero_r <= zero_r;
      out_ovf_r  <= ovf_w_r;
    end
  end

  assign sts.mul_done = (mcnt_r == MCNT_W'(CNT_W - 1));
  assign sts.div_done = div_done;
  assign sts.d_zero   = (d_r == '0);

  assign out_r_squared            = out_rsq_r;
  assign out_total_sum_squares    = out_tss_r;
  assign out_residual_sum_squares = out_rss_r;
  assign out_sample_total         = out_cnt_r;
  assign out_zero_total           = out_zero_r;
  assign out_count_overflow       = out_ovf_r;

endmodule

// ----- src/rsqa_ctrl.sv -----
// Controller state machine that sequences accumulation, products, divisions and output.
module rsqa_ctrl import rsqa_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_last_sample,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  rsqa_sts_t sts,
  output rsqa_cmd_t cmd
);

  rsqa_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_ACC;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    cmd.div_sel   = DIV_SST;
    unique case (state_r)
      ST_ACC: begin
        if (in_valid) begin
          cmd.acc = 1'b1;
          if (in_last_sample) begin
            cmd.capture = 1'b1;
            state_nxt   = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        cmd.mul_step = 1'b1;
        if (sts.mul_done) begin
          state_nxt = ST_SUB;
        end
      end
      ST_SUB: begin
        cmd.sub   = 1'b1;
        state_nxt = ST_DIV1_GO;
      end
      ST_DIV1_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_DIV1_WAIT;
      end
      ST_DIV1_WAIT: begin
        if (sts.div_done) begin
          cmd.sst_load = 1'b1;
          state_nxt    = ST_DIV2_GO;
        end
      end
      ST_DIV2_GO: begin
        cmd.div_sel = DIV_RSQ;
        if (sts.d_zero) begin
          cmd.zero_load = 1'b1;
          state_nxt     = ST_OUT;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_DIV2_WAIT;
        end
      end
      ST_DIV2_WAIT: begin
        cmd.div_sel = DIV_RSQ;
        if (sts.div_done) begin
          cmd.rsq_load = 1'b1;
          state_nxt    = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_ACC;
        end
      end
      default: begin
        state_nxt = ST_ACC;
      end
    endcase
  end

  assign in_stall  = (state_r != ST_ACC);
  assign out_valid = out_valid_r;

endmodule

// ----- src/r_squared_accumulator_core.sv -----
// Top level of the streaming R squared accumulator.
//
// Pairs of known and estimated samples are accumulated at one transaction per cycle while
// in_stall is low. The transaction marked last closes the set: in_stall then stays high
// while a 13-step shift-add multiplier forms n times the sums and one shared restoring
// divider, one quotient bit per cycle, produces first the total sum of squares and then R
// squared in signed Q3.16 (the second division is skipped when the total is zero). The
// result waits in an output register, so the next set is accepted while it is pending.
// Pairs past the 4096th in a set are dropped and flagged; a zero total is flagged as well.
module r_squared_accumulator_core import rsqa_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_known_value,
  input  logic signed [SAMPLE_BITS-1:0] in_estimated_value,
  input  logic                          in_last_sample,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [RSQ_W-1:0]       out_r_squared,
  output logic [TSS_W-1:0]              out_total_sum_squares,
  output logic [RSS_W-1:0]              out_residual_sum_squares,
  output logic [CNT_W-1:0]              out_sample_total,
  output logic                          out_zero_total,
  output logic                          out_count_overflow
);

  rsqa_cmd_t cmd;
  rsqa_sts_t sts;

  rsqa_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_last_sample (in_last_sample),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .sts            (sts),
    .cmd            (cmd)
  );

  rsqa_dp u_dp (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .cmd                      (cmd),
    .sts                      (sts),
    .in_known_value           (in_known_value),
    .in_estimated_value       (in_estimated_value),
    .out_r_squared            (out_r_squared),
    .out_total_sum_squares    (out_total_sum_squares),
    .out_residual_sum_squares (out_residual_sum_squares),
    .out_sample_total         (out_sample_total),
    .out_zero_total           (out_zero_total),
    .out_count_overflow       (out_count_overflow)
  );

endmodule

// ----- tb/tb_r_squared_accumulator_core.sv -----
// Self-checking testbench for the streaming R squared accumulator core.
module tb_r_squared_accumulator_core;
  import rsqa_pkg::*;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] known;
    logic signed [SAMPLE_BITS-1:0] est;
    logic                          last;
  } sample_pair_t;

  typedef struct packed {
    logic [RSQ_W-1:0] rsq;
    logic [TSS_W-1:0] tss;
    logic [RSS_W-1:0] rss;
    logic [CNT_W-1:0] cnt;
    logic             zero;
    logic             ovf;
  } fit_result_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic signed [SAMPLE_BITS-1:0] in_known_value = '0;
  logic signed [SAMPLE_BITS-1:0] in_estimated_value = '0;
  logic                          in_last_sample = 1'b0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic signed [RSQ_W-1:0]       out_r_squared;
  logic [TSS_W-1:0]              out_total_sum_squares;
  logic [RSS_W-1:0]              out_residual_sum_squares;
  logic [CNT_W-1:0]              out_sample_total;
  logic                          out_zero_total;
  logic                          out_count_overflow;

  sample_pair_t pair_stream[$];
  fit_result_t  pending_fits[$];

  longint      fit_sum = 0;
  logic [63:0] fit_sq = '0;
  logic [63:0] fit_res = '0;
  int          fit_n = 0;
  logic        fit_ovf = 1'b0;

  int   sent = 0;
  int   accepted = 0;
  int   fits_seen = 0;
  int   zero_seen = 0;
  int   ovf_seen = 0;
  int   sat_seen = 0;
  int   mismatches = 0;
  int   hold_left = 0;
  logic hold_done = 1'b0;
  int   send_idle_pct;
  int   recv_idle_pct;

  r_squared_accumulator_core uut (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .in_valid                 (in_valid),
    .in_stall                 (in_stall),
    .in_known_value           (in_known_value),
    .in_estimated_value       (in_estimated_value),
    .in_last_sample           (in_last_sample),
    .out_valid                (out_valid),
    .out_stall                (out_stall),
    .out_r_squared            (out_r_squared),
    .out_total_sum_squares    (out_total_sum_squares),
    .out_residual_sum_squares (out_residual_sum_squares),
    .out_sample_total         (out_sample_total),
    .out_zero_total           (out_zero_total),
    .out_count_overflow       (out_count_overflow)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #5000000;
    $display("Timed out with %0d pairs waiting and %0d results outstanding.",
             pair_stream.size(), pending_fits.size());
    $display("TB_ERROR");
    $finish;
  end

  task automatic absorb_pair(input logic signed [SAMPLE_BITS-1:0] k,
                             input logic signed [SAMPLE_BITS-1:0] e, input logic last);
    logic [63:0]  ak;
    logic [63:0]  ad;
    longint       dk;
    logic [63:0]  n;
    logic [63:0]  absk;
    logic [63:0]  sq;
    logic [63:0]  dsum;
    logic [63:0]  d;
    logic [127:0] quo;
    longint       r;
    fit_result_t  res;
    if (fit_n >= MAX_SAMPLES) begin
      fit_ovf = 1'b1;
    end else begin
      dk = longint'(k) - longint'(e);
      ak = (k < 0) ? 64'(-longint'(k)) : 64'(longint'(k));
      ad = (dk < 0) ? 64'(-dk) : 64'(dk);
      fit_sum = fit_sum + longint'(k);
      fit_sq = fit_sq + ak * ak;
      fit_res = fit_res + ad * ad;
      fit_n++;
    end
    if (last) begin
      n = 64'(fit_n);
      absk = (fit_sum < 0) ? 64'(-fit_sum) : 64'(fit_sum);
      sq = absk * absk;
      dsum = n * fit_sq;
      d = (dsum > sq) ? dsum - sq : 64'd0;
      res.tss = TSS_W'(d / n);
      res.rss = RSS_W'(fit_res);
      res.cnt = CNT_W'(fit_n);
      res.ovf = fit_ovf;
      if (d == 0) begin
        res.zero = 1'b1;
        res.rsq = '0;
      end else begin
        res.zero = 1'b0;
        quo = ({64'd0, n * fit_res} << FRACTION_BITS) / {64'd0, d};
        if (quo >= 128'((1 << FRACTION_BITS) + (1 << (RSQ_W - 1)))) begin
          res.rsq = RSQ_MIN;
        end else begin
          r = longint'(1 << FRACTION_BITS) - longint'(quo[63:0]);
          res.rsq = RSQ_W'(r);
        end
      end
      pending_fits.push_back(res);
      fit_sum = 0;
      fit_sq = '0;
      fit_res = '0;
      fit_n = 0;
      fit_ovf = 1'b0;
    end
  endtask

  always_comb begin
    send_idle_pct = (sent < 900) ? 31 : (sent < 1800) ? 84 : 0;
    recv_idle_pct = (sent < 900) ? 84 : (sent < 1800) ? 31 : 0;
  end

  always @(posedge clk) begin : driver_proc
    sample_pair_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        absorb_pair(in_known_value, in_estimated_value, in_last_sample);
        accepted <= accepted + 1;
      end
      if (!in_valid || !in_stall) begin
        if (pair_stream.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pair_stream.pop_front();
          in_valid <= 1'b1;
          in_known_value <= nxt.known;
          in_estimated_value <= nxt.est;
          in_last_sample <= nxt.last;
          sent <= sent + 1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // The output is held off for a long stretch once, so the block fills and backs up its input.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && sent >= 300) begin
      hold_left <= 1200;
      hold_done <= 1'b1;
    end
  end

  always @(posedge clk) begin : monitor_proc
    fit_result_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        fits_seen++;
        if (out_zero_total === 1'b1) zero_seen++;
        if (out_count_overflow === 1'b1) ovf_seen++;
        if (out_r_squared === RSQ_MIN) sat_seen++;
        if (pending_fits.size() == 0) begin
          if (mismatches < 10) begin
            $display("Unexpected result transaction: rsq=%0d n=%0d", out_r_squared,
                     out_sample_total);
          end
          mismatches++;
        end else begin
          want = pending_fits.pop_front();
          if (want.rsq !== out_r_squared || want.tss !== out_total_sum_squares ||
              want.rss !== out_residual_sum_squares || want.cnt !== out_sample_total ||
              want.zero !== out_zero_total || want.ovf !== out_count_overflow) begin
            if (mismatches < 10) begin
              $display("Mismatch: expected rsq=%0d tss=%0d rss=%0d n=%0d zero=%b ovf=%b",
                       $signed(want.rsq), want.tss, want.rss, want.cnt, want.zero, want.ovf);
              $display("          actual   rsq=%0d tss=%0d rss=%0d n=%0d zero=%b ovf=%b",
                       out_r_squared, out_total_sum_squares, out_residual_sum_squares,
                       out_sample_total, out_zero_total, out_count_overflow);
            end
            mismatches++;
          end
        end
      end
      out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_idle_pct);
    end
  end

  function automatic logic signed [SAMPLE_BITS-1:0] clamp_sample(input int v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return SAMPLE_BITS'(v);
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] any_sample();
    return SAMPLE_BITS'($urandom_range(65535));
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] edge_sample();
    case ($urandom_range(4))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sh0000;
      3: return 16'shffff;
      default: return 16'sh0001;
    endcase
  endfunction

  task automatic add_pair(input int k, input int e, input logic last);
    sample_pair_t p;
    p.known = clamp_sample(k);
    p.est = clamp_sample(e);
    p.last = last;
    pair_stream.push_back(p);
  endtask

  task automatic add_random_set(input int len);
    int mode;
    int center;
    int spread;
    int noise;
    int fixed;
    int k;
    int e;
    mode = $urandom_range(99);
    center = int'(any_sample());
    spread = ($urandom_range(2) == 0) ? 15 : ($urandom_range(1) == 0) ? 255 : 4095;
    noise = $urandom_range(1, 300);
    fixed = int'(any_sample());
    for (int i = 0; i < len; i++) begin
      if (mode < 40) begin
        k = int'(clamp_sample(center + int'($urandom_range(2 * spread)) - spread));
        e = k + int'($urandom_range(2 * noise)) - noise;
      end else if (mode < 60) begin
        k = int'(any_sample());
        e = int'(any_sample());
      end else if (mode < 75) begin
        k = int'(any_sample());
        e = k;
      end else if (mode < 90) begin
        k = int'(edge_sample());
        e = int'(edge_sample());
      end else begin
        k = fixed;
        e = int'(any_sample());
      end
      add_pair(k, e, i == len - 1);
    end
  endtask

  initial begin : stimulus_proc
    int total;
    int len;
    int r;
    // A single pair, and a set of equal known values, both leave no total to divide by.
    add_pair(-32768, 32767, 1'b1);
    add_pair(32767, -32768, 1'b0);
    add_pair(32767, -32768, 1'b0);
    add_pair(32767, 0, 1'b1);
    // A perfect estimate gives exactly one.
    add_pair(-32768, -32768, 1'b0);
    add_pair(32767, 32767, 1'b0);
    add_pair(0, 0, 1'b0);
    add_pair(100, 100, 1'b1);
    // A tiny spread with huge residuals drives R squared to its lower bound.
    add_pair(0, -32768, 1'b0);
    add_pair(1, 32767, 1'b0);
    add_pair(0, -32768, 1'b0);
    add_pair(1, 32767, 1'b1);
    add_pair(1000, 900, 1'b0);
    add_pair(-2000, -1800, 1'b0);
    add_pair(3000, 3100, 1'b1);
    add_pair(-1, 1, 1'b0);
    add_pair(-32768, 32767, 1'b1);
    total = 0;
    while (total < 1800) begin
      r = $urandom_range(99);
      len = (r < 70) ? $urandom_range(1, 8) : (r < 95) ? $urandom_range(9, 40) :
            $urandom_range(41, 200);
      add_random_set(len);
      total += len;
    end
    // One set at the extremes that fills to capacity and then runs past it.
    for (int i = 0; i < MAX_SAMPLES + 2; i++) begin
      if (i % 2 == 0) add_pair(-32768, 32767, i == MAX_SAMPLES + 1);
      else add_pair(32767, -32768, i == MAX_SAMPLES + 1);
    end
  end

  initial begin
    wait (rst_n === 1'b1);
    while (pair_stream.size() != 0 || in_valid || pending_fits.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    $display("Run covered %0d accepted pairs and %0d checked results.", accepted, fits_seen);
    $display("Of these, %0d had a zero total, %0d overflowed and %0d saturated low.",
             zero_seen, ovf_seen, sat_seen);
    if (mismatches == 0 && pending_fits.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- r_squared_accumulator_core.f -----
src/rsqa_pkg.sv
src/rsqa_div.sv
src/rsqa_dp.sv
src/rsqa_ctrl.sv
src/r_squared_accumulator_core.sv
tb/tb_r_squared_accumulator_core.sv
